>>> hdl/ts_audio_pes_adts_extractor_top_defines.svh
// ----------------------------------------------------------------------------
// ts_audio_pes_adts_extractor_top_defines
// assertion macros shared by the extractor modules
// ----------------------------------------------------------------------------
`ifndef TS_AUDIO_PES_ADTS_EXTRACTOR_TOP_DEFINES_SVH
`define TS_AUDIO_PES_ADTS_EXTRACTOR_TOP_DEFINES_SVH

// condition holds at every clock edge outside reset
`define TSAX_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TSAX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TSAX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tsax_pkg.sv
// ----------------------------------------------------------------------------
// tsax_pkg
// shared constants and types of the audio stream extractor
// ----------------------------------------------------------------------------
`default_nettype none

package tsax_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h47;
  localparam logic [7:0] PKT_LAST_POS  = 8'd187;
  localparam logic [8:0] PKT_LEN       = 9'd188;
  localparam logic [8:0] PES_START_MAX = 9'd179;
  localparam logic [8:0] PAY_START_RST = 9'd4;
  localparam logic [7:0] TAG_ID0       = 8'h49;
  localparam logic [7:0] TAG_ID1       = 8'h44;
  localparam logic [7:0] TAG_ID2       = 8'h33;
  localparam logic [7:0] ADTS_SYNC     = 8'hFF;
  localparam logic [28:0] FOOTER_LEN   = 29'd10;

  // words caused by one input byte
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/tsax_core.sv
// ----------------------------------------------------------------------------
// tsax_core
// per-byte parser state: transport packets, pes headers, id3 tags, adts sync
// ----------------------------------------------------------------------------
`default_nettype none

module tsax_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          end_i,
  output tsax_pkg::res_t     res_o
);

  typedef enum logic [2:0] {
    MODE_START = 3'b001,
    MODE_TS    = 3'b010,
    MODE_RAW   = 3'b100
  } mode_e;

  typedef enum logic [5:0] {
    RAW_SEEK = 6'b000001,
    RAW_HDR  = 6'b000010,
    RAW_SKIP = 6'b000100,
    RAW_HELD = 6'b001000,
    RAW_PASS = 6'b010000,
    RAW_DROP = 6'b100000
  } raw_e;

  typedef enum logic [5:0] {
    PES_IDLE = 6'b000001,
    PES_Z0   = 6'b000010,
    PES_Z1   = 6'b000100,
    PES_ONE  = 6'b001000,
    PES_HDR  = 6'b010000,
    PES_BODY = 6'b100000
  } pes_e;

  mode_e        mode_q, mode_d;
  logic [7:0]   pos_q, pos_d;
  logic         bad_q, bad_d;
  logic [12:0]  pid_q, pid_d;
  logic         unit_q, unit_d;
  logic [1:0]   fc_q, fc_d;
  logic [8:0]   ps_q, ps_d;
  pes_e         pes_q, pes_d;
  logic [8:0]   pskip_q, pskip_d;
  logic [12:0]  apid_q, apid_d;
  logic         apv_q, apv_d;
  logic [3:0]   hpos_q, hpos_d;
  logic [28:0]  tskip_q, tskip_d;
  logic         foot_q, foot_d;
  raw_e         raw_q, raw_d;

  logic         is_pay;
  logic [8:0]   rel;
  tsax_pkg::res_t res;

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    bad_d   = bad_q;
    pid_d   = pid_q;
    unit_d  = unit_q;
    fc_d    = fc_q;
    ps_d    = ps_q;
    pes_d   = pes_q;
    pskip_d = pskip_q;
    apid_d  = apid_q;
    apv_d   = apv_q;
    hpos_d  = hpos_q;
    tskip_d = tskip_q;
    foot_d  = foot_q;
    raw_d   = raw_q;
    is_pay  = 1'b0;
    rel     = '0;
    res     = '0;

    if (mode_q == MODE_START) begin
      mode_d = (byte_i == tsax_pkg::SYNC_BYTE) ? MODE_TS : MODE_RAW;
    end

    if (mode_d == MODE_TS) begin
      if (pos_q == 8'd0) begin
        bad_d   = (byte_i != tsax_pkg::SYNC_BYTE);
        pes_d   = PES_IDLE;
        pskip_d = '0;
      end else if (pos_q == 8'd1) begin
        unit_d = byte_i[6];
        pid_d  = {byte_i[4:0], 8'h00};
      end else if (pos_q == 8'd2) begin
        pid_d = {pid_q[12:8], byte_i};
      end else if (pos_q == 8'd3) begin
        fc_d = byte_i[5:4];
        ps_d = tsax_pkg::PAY_START_RST;
      end else if (pos_q == 8'd4 && fc_q[1]) begin
        ps_d = 9'd5 + {1'b0, byte_i};
      end

      is_pay = (pos_q >= 8'd4) && !bad_d && fc_d[0] && (ps_d < tsax_pkg::PKT_LEN) &&
               ({1'b0, pos_q} >= ps_d);
      rel = {1'b0, pos_q} - ps_d;

      if (is_pay) begin
        if (!unit_d) begin
          if (apv_q && pid_d == apid_q) begin
            res.cnt = 2'd1;
            res.b0  = byte_i;
          end
        end else if (rel == 9'd0) begin
          pes_d = (ps_d <= tsax_pkg::PES_START_MAX && byte_i == 8'h00) ? PES_Z0 : PES_IDLE;
        end else if (rel == 9'd1) begin
          pes_d = (pes_q == PES_Z0 && byte_i == 8'h00) ? PES_Z1 : PES_IDLE;
        end else if (rel == 9'd2) begin
          pes_d = (pes_q == PES_Z1 && byte_i == 8'h01) ? PES_ONE : PES_IDLE;
        end else if (rel == 9'd3) begin
          if (pes_q == PES_ONE && byte_i[7:5] == 3'b110) begin
            if (!apv_q) begin
              apid_d = pid_q;
              apv_d  = 1'b1;
            end
            pes_d = (pid_q == apid_d) ? PES_HDR : PES_IDLE;
          end else begin
            pes_d = PES_IDLE;
          end
        end else if (rel == 9'd8) begin
          if (pes_q == PES_HDR) begin
            pskip_d = {1'b0, byte_i};
            pes_d   = PES_BODY;
          end
        end else if (rel > 9'd8 && pes_q == PES_BODY) begin
          if (pskip_q != 9'd0) begin
            pskip_d = pskip_q - 9'd1;
          end else begin
            res.cnt = 2'd1;
            res.b0  = byte_i;
          end
        end
      end

      pos_d = (pos_q == tsax_pkg::PKT_LAST_POS) ? 8'd0 : pos_q + 8'd1;
    end else begin
      case (raw_q)
        RAW_SEEK: begin
          if (byte_i == tsax_pkg::TAG_ID0) begin
            raw_d   = RAW_HDR;
            hpos_d  = 4'd1;
            tskip_d = '0;
            foot_d  = 1'b0;
          end else if (byte_i == tsax_pkg::ADTS_SYNC) begin
            raw_d = RAW_HELD;
          end else begin
            raw_d = RAW_DROP;
          end
        end
        RAW_HDR: begin
          if ((hpos_q == 4'd1 && byte_i != tsax_pkg::TAG_ID1) ||
              (hpos_q == 4'd2 && byte_i != tsax_pkg::TAG_ID2)) begin
            raw_d = RAW_DROP;
          end else begin
            if (hpos_q == 4'd5) begin
              foot_d = byte_i[4];
            end else if (hpos_q >= 4'd6) begin
              tskip_d = {1'b0, tskip_q[20:0], byte_i[6:0]};
            end
            if (hpos_q >= 4'd9) begin
              hpos_d  = 4'd0;
              tskip_d = tskip_d + (foot_q ? tsax_pkg::FOOTER_LEN : 29'd0);
              raw_d   = (tskip_d != 29'd0) ? RAW_SKIP : RAW_SEEK;
            end else begin
              hpos_d = hpos_q + 4'd1;
            end
          end
        end
        RAW_SKIP: begin
          if (tskip_q > 29'd1) begin
            tskip_d = tskip_q - 29'd1;
          end else begin
            tskip_d = '0;
            raw_d   = RAW_SEEK;
          end
        end
        RAW_HELD: begin
          if (byte_i[7:4] == 4'hF) begin
            res.cnt = 2'd2;
            res.b0  = tsax_pkg::ADTS_SYNC;
            res.b1  = byte_i;
            raw_d   = RAW_PASS;
          end else begin
            raw_d = RAW_DROP;
          end
        end
        RAW_PASS: begin
          res.cnt = 2'd1;
          res.b0  = byte_i;
        end
        default: begin
          raw_d = RAW_DROP;
        end
      endcase
    end
  end

  always_comb begin
    res_o     = res;
    res_o.cnt = fire_i ? res.cnt : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_START;
      pos_q   <= '0;
      bad_q   <= 1'b0;
      pid_q   <= '0;
      unit_q  <= 1'b0;
      fc_q    <= '0;
      ps_q    <= tsax_pkg::PAY_START_RST;
      pes_q   <= PES_IDLE;
      pskip_q <= '0;
      apid_q  <= '0;
      apv_q   <= 1'b0;
      hpos_q  <= '0;
      tskip_q <= '0;
      foot_q  <= 1'b0;
      raw_q   <= RAW_SEEK;
    end else if (fire_i) begin
      if (end_i) begin
        mode_q  <= MODE_START;
        pos_q   <= '0;
        bad_q   <= 1'b0;
        pid_q   <= '0;
        unit_q  <= 1'b0;
        fc_q    <= '0;
        ps_q    <= tsax_pkg::PAY_START_RST;
        pes_q   <= PES_IDLE;
        pskip_q <= '0;
        apid_q  <= '0;
        apv_q   <= 1'b0;
        hpos_q  <= '0;
        tskip_q <= '0;
        foot_q  <= 1'b0;
        raw_q   <= RAW_SEEK;
      end else begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        bad_q   <= bad_d;
        pid_q   <= pid_d;
        unit_q  <= unit_d;
        fc_q    <= fc_d;
        ps_q    <= ps_d;
        pes_q   <= pes_d;
        pskip_q <= pskip_d;
        apid_q  <= apid_d;
        apv_q   <= apv_d;
        hpos_q  <= hpos_d;
        tskip_q <= tskip_d;
        foot_q  <= foot_d;
        raw_q   <= raw_d;
      end
    end
  end

`include "ts_audio_pes_adts_extractor_top_defines.svh"

  `TSAX_ASSERT_ALWAYS(a_pos_range, pos_q <= tsax_pkg::PKT_LAST_POS, "packet position out of range")
  `TSAX_ASSERT_ALWAYS(a_hpos_range, hpos_q <= 4'd9, "tag header position out of range")
  `TSAX_ASSERT_IMPL(a_pair_sync, res_o.cnt == 2'd2, res_o.b0 == tsax_pkg::ADTS_SYNC && raw_q == RAW_HELD, "word pair without held sync")

endmodule

`default_nettype wire

>>> hdl/tsax_outq.sv
// ----------------------------------------------------------------------------
// tsax_outq
// four-entry result queue, takes up to two words per cycle, gives one while ready
// ----------------------------------------------------------------------------
`default_nettype none

module tsax_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tsax_pkg::res_t res_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  logic [8:0] mem_q [4];
  logic [1:0] wp_q, wp_d;
  logic [1:0] rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign room_o      = (cnt_q <= 3'd2);
  assign out_byte_o  = mem_q[rp_q][8:1];
  assign out_last_o  = mem_q[rp_q][0];

  assign wp_d  = wp_q + res_i.cnt;
  assign rp_d  = rp_q + {1'b0, pop};
  assign cnt_d = cnt_q + {1'b0, res_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (res_i.cnt != 2'd0) begin
      mem_q[wp_q] <= {res_i.b0, (res_i.cnt == 2'd1)};
    end
    if (res_i.cnt == 2'd2) begin
      mem_q[wp_q + 2'd1] <= {res_i.b1, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

`include "ts_audio_pes_adts_extractor_top_defines.svh"

  `TSAX_ASSERT_IMPL(a_push_room, res_i.cnt != 2'd0, cnt_q <= 3'd2, "push without room")
  `TSAX_ASSERT_ALWAYS(a_cnt_max, cnt_q <= 3'd4, "queue count overflow")
  `TSAX_ASSERT_NEXT(a_cnt_track, res_i.cnt == 2'd2 && !pop,
                    cnt_q == $past(cnt_q) + 3'd2, "queue count lost a pair")

endmodule

`default_nettype wire

>>> hdl/ts_audio_pes_adts_extractor_top.sv
// ----------------------------------------------------------------------------
// ts_audio_pes_adts_extractor_top
// passes the audio elementary stream bytes of a media segment: transport
// packets with audio pes, or raw adts after optional id3 tags
// ----------------------------------------------------------------------------
// channel | handshake               | word
// in      | in_valid_i / in_ready_o | seg_byte_i, seg_end_i
// out     | out_valid_o / out_ready_i | audio_byte_o, run_last_o
//
// one input byte a cycle while the queue has room: an input register feeds
// the parser, whose words go into a four-entry queue in front of the output.
// an accepted byte is registered, parsed, then written into the queue.
// a byte giving two words (adts sync release) puts both in the queue at once.
// input stalls when a byte is staged and the queue lacks two free entries.
// reset returns to start of segment; so does the byte marked seg_end.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_audio_pes_adts_extractor_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] seg_byte_i,
  input  wire logic       seg_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      audio_byte_o,
  output logic            run_last_o
);

  logic           stg_q, stg_d;
  logic [7:0]     stg_byte_q;
  logic           stg_end_q;
  logic           room;
  logic           fire;
  logic           accept;
  tsax_pkg::res_t res;

  assign fire       = stg_q && room;
  assign in_ready_o = !stg_q || fire;
  assign accept     = in_valid_i && in_ready_o;
  assign stg_d      = accept ? 1'b1 : (fire ? 1'b0 : stg_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_byte_q <= seg_byte_i;
      stg_end_q  <= seg_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= 1'b0;
    end else begin
      stg_q <= stg_d;
    end
  end

  tsax_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (stg_byte_q),
    .end_i  (stg_end_q),
    .res_o  (res)
  );

  tsax_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (audio_byte_o),
    .out_last_o  (run_last_o)
  );

`include "ts_audio_pes_adts_extractor_top_defines.svh"

  `TSAX_ASSERT_NEXT(a_stage_hold, stg_q && !room, stg_q, "staged byte lost while stalled")
  `TSAX_ASSERT_NEXT(a_stage_load, accept, stg_q, "accepted byte not staged")
  `TSAX_ASSERT_IMPL(a_no_fire_empty, res.cnt != 2'd0, stg_q, "words without staged byte")

endmodule

`default_nettype wire
